// ===== design/qbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// qbpt_pkg
// Shared types and constants for the quadratic Bezier path tessellator.
// ----------------------------------------------------------------------------
package qbpt_pkg;

  localparam int COORD_W     = 16;
  localparam int OUT_W       = 23;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
  } segment_t;

endpackage

// ===== design/quadratic_bezier_path_tessellator.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_path_tessellator
// Chains quadratic Bezier segments from streamed control points and emits
// STEPS exact samples per segment in units of 1/(STEPS*STEPS).
// ----------------------------------------------------------------------------
// The sample generator loads each segment in ST_IDLE, then emits samples in
//   ST_RUN, one sample per cycle while out_ready does not stall the output.
// The 2-entry segment queue lets points be taken while samples drain.
// Reset (rst, synchronous): clears path state, queue and output valid.
module quadratic_bezier_path_tessellator #(
  parameter int STEPS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              start_path,
  input  logic signed [qbpt_pkg::COORD_W-1:0] point_x,
  input  logic signed [qbpt_pkg::COORD_W-1:0] point_y,
  input  logic signed [qbpt_pkg::COORD_W-1:0] point_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qbpt_pkg::OUT_W-1:0] curve_x,
  output logic signed [qbpt_pkg::OUT_W-1:0] curve_y,
  output logic signed [qbpt_pkg::OUT_W-1:0] curve_z,
  output logic                              segment_done
);
  import qbpt_pkg::*;

  point_t   pt;
  segment_t push_data;
  segment_t rd_data;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;

  assign pt.x = point_x;
  assign pt.y = point_y;
  assign pt.z = point_z;

  qbpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_path (start_path),
    .pt         (pt),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  qbpt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  qbpt_back #(
    .STEPS (STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .seg          (rd_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .curve_x      (curve_x),
    .curve_y      (curve_y),
    .curve_z      (curve_z),
    .segment_done (segment_done)
  );

endmodule

// ===== design/qbpt_front.sv =====
// ----------------------------------------------------------------------------
// qbpt_front
// Accepts control points, tracks path state and pushes complete segments.
// ----------------------------------------------------------------------------
module qbpt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            start_path,
  input  qbpt_pkg::point_t pt,
  input  logic            q_full,
  output logic            push,
  output qbpt_pkg::segment_t push_data
);
  import qbpt_pkg::*;

  point_t anchor_point;
  point_t middle_point;
  logic   expect_middle;
  logic   have_anchor;
  logic   accept;
  logic   is_start;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = start_path || !have_anchor;
  assign push     = accept && !is_start && !expect_middle;

  assign push_data.p0 = anchor_point;
  assign push_data.p1 = middle_point;
  assign push_data.p2 = pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_point  <= '0;
      middle_point  <= '0;
      expect_middle <= 1'b0;
      have_anchor   <= 1'b0;
    end else if (accept) begin
      if (is_start) begin
        anchor_point  <= pt;
        have_anchor   <= 1'b1;
        expect_middle <= 1'b1;
      end else if (expect_middle) begin
        middle_point  <= pt;
        expect_middle <= 1'b0;
      end else begin
        anchor_point  <= pt;
        expect_middle <= 1'b1;
      end
    end
  end

  a_close_rearms: assert property (@(posedge clk) disable iff (rst)
    push |=> expect_middle && have_anchor)
    else $error("closing point did not rearm middle expectation");

endmodule

// ===== design/qbpt_queue.sv =====
// ----------------------------------------------------------------------------
// qbpt_queue
// Short segment queue between the front and the sample generator.
// ----------------------------------------------------------------------------
module qbpt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qbpt_pkg::segment_t push_data,
  input  logic               pop,
  output qbpt_pkg::segment_t rd_data,
  output logic               empty,
  output logic               full
);
  import qbpt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  segment_t            entry [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_data = entry[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("segment pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("segment popped from empty queue");

endmodule

// ===== design/qbpt_back.sv =====
// ----------------------------------------------------------------------------
// qbpt_back
// Sample generator: forward differences in k, one sample per unstalled cycle.
// ----------------------------------------------------------------------------
module qbpt_back #(
  parameter int STEPS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  qbpt_pkg::segment_t                seg,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qbpt_pkg::OUT_W-1:0] curve_x,
  output logic signed [qbpt_pkg::OUT_W-1:0] curve_y,
  output logic signed [qbpt_pkg::OUT_W-1:0] curve_z,
  output logic                              segment_done
);
  import qbpt_pkg::*;

  localparam int W   = $clog2(STEPS * STEPS) + COORD_W + 2;
  localparam int K_W = $clog2(STEPS);
  localparam logic signed [W-1:0] C_V0 = W'(STEPS * STEPS);
  localparam logic signed [W-1:0] C_D0 = W'(1 - 2 * STEPS);
  localparam logic signed [W-1:0] C_D1 = W'(2 * (STEPS - 1));
  localparam logic signed [W-1:0] SAT_MAX = W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [W-1:0] SAT_MIN = -W'(1 << (OUT_W - 1));

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                   state;
  logic [K_W-1:0]           k;
  logic signed [W-1:0]      v   [3];
  logic signed [W-1:0]      d   [3];
  logic signed [W-1:0]      dd  [3];
  logic signed [W-1:0]      p0w [3];
  logic signed [W-1:0]      p1w [3];
  logic signed [W-1:0]      p2w [3];
  logic signed [OUT_W-1:0]  sat [3];
  logic                     emit;
  logic                     last;

  function automatic logic signed [OUT_W-1:0] saturate(input logic signed [W-1:0] val);
    logic signed [OUT_W-1:0] r;
    if (val > SAT_MAX) begin
      r = SAT_MAX[OUT_W-1:0];
    end else if (val < SAT_MIN) begin
      r = SAT_MIN[OUT_W-1:0];
    end else begin
      r = val[OUT_W-1:0];
    end
    return r;
  endfunction

  assign p0w[0] = W'(seg.p0.x);
  assign p0w[1] = W'(seg.p0.y);
  assign p0w[2] = W'(seg.p0.z);
  assign p1w[0] = W'(seg.p1.x);
  assign p1w[1] = W'(seg.p1.y);
  assign p1w[2] = W'(seg.p1.z);
  assign p2w[0] = W'(seg.p2.x);
  assign p2w[1] = W'(seg.p2.y);
  assign p2w[2] = W'(seg.p2.z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i] = saturate(v[i]);
    end
  end

  assign pop  = (state == ST_IDLE) && !q_empty;
  assign emit = (state == ST_RUN) && (!out_valid || out_ready);
  assign last = (k == K_W'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_RUN;
            k     <= '0;
          end
        end
        ST_RUN: begin
          if (emit) begin
            if (last) begin
              state <= ST_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 3; i++) begin
        v[i]  <= C_V0 * p0w[i];
        d[i]  <= C_D0 * p0w[i] + C_D1 * p1w[i] + p2w[i];
        dd[i] <= (p0w[i] - (p1w[i] <<< 1) + p2w[i]) <<< 1;
      end
    end else if (emit) begin
      for (int i = 0; i < 3; i++) begin
        v[i] <= v[i] + d[i];
        d[i] <= d[i] + dd[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      curve_x      <= sat[0];
      curve_y      <= sat[1];
      curve_z      <= sat[2];
      segment_done <= last;
    end
  end

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (k <= K_W'(STEPS - 1)))
    else $error("sample index out of range");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    emit && last |=> (state == ST_IDLE) && segment_done)
    else $error("segment did not end after last sample");

endmodule

// ===== test/quadratic_bezier_path_tessellator_test.sv =====
// ----------------------------------------------------------------------------
// quadratic_bezier_path_tessellator_test
// Streams control points into the tessellator with random gaps on both
// channels and compares every curve sample against an exact integer model.
// ----------------------------------------------------------------------------
module quadratic_bezier_path_tessellator_test;
  import qbpt_pkg::*;

  localparam int STEPS = 10;
  localparam int RANDOM_POINTS = 210;
  localparam longint SAMPLE_MAX = 4194303;
  localparam longint SAMPLE_MIN = -4194304;

  typedef struct {
    logic   first;
    point_t pt;
  } ctrl_point_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    last;
  } curve_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      start_path = 1'b0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [OUT_W-1:0]   curve_x;
  logic signed [OUT_W-1:0]   curve_y;
  logic signed [OUT_W-1:0]   curve_z;
  logic                      segment_done;

  ctrl_point_t   pending_points[$];
  curve_sample_t curve_expected[$];

  point_t seg_anchor = '0;
  point_t seg_middle = '0;
  logic   want_middle = 1'b0;
  logic   path_open = 1'b0;

  int   total_points = 0;
  int   points_taken = 0;
  int   err_count = 0;
  logic in_fire = 1'b0;
  logic hold_off = 1'b0;
  int   send_idle_pct;
  int   recv_idle_pct;

  quadratic_bezier_path_tessellator #(
    .STEPS(STEPS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_path  (start_path),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .curve_z     (curve_z),
    .segment_done(segment_done)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [OUT_W-1:0] clamp_sample(input longint v);
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      v = SAMPLE_MIN;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'($signed($urandom_range(200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_point(input logic first, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input logic signed [COORD_W-1:0] z);
    ctrl_point_t it;
    it.first = first;
    it.pt.x = x;
    it.pt.y = y;
    it.pt.z = z;
    pending_points = {pending_points, it};
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch: %s", msg);
  endtask

  // path state update and sample prediction for one accepted point
  task automatic predict_samples(input ctrl_point_t it);
    longint        wa;
    longint        wm;
    longint        wc;
    curve_sample_t s;
    if (it.first || !path_open) begin
      seg_anchor = it.pt;
      path_open = 1'b1;
      want_middle = 1'b1;
    end else if (want_middle) begin
      seg_middle = it.pt;
      want_middle = 1'b0;
    end else begin
      for (int k = 0; k < STEPS; k++) begin
        wa = longint'(STEPS - k) * longint'(STEPS - k);
        wm = 2 * longint'(k) * longint'(STEPS - k);
        wc = longint'(k) * longint'(k);
        s.x = clamp_sample(wa * longint'(seg_anchor.x) + wm * longint'(seg_middle.x) +
                           wc * longint'(it.pt.x));
        s.y = clamp_sample(wa * longint'(seg_anchor.y) + wm * longint'(seg_middle.y) +
                           wc * longint'(it.pt.y));
        s.z = clamp_sample(wa * longint'(seg_anchor.z) + wm * longint'(seg_middle.z) +
                           wc * longint'(it.pt.z));
        s.last = (k == STEPS - 1);
        curve_expected = {curve_expected, s};
      end
      seg_anchor = it.pt;
      want_middle = 1'b1;
    end
  endtask

  task automatic check_sample();
    curve_sample_t s;
    if (curve_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected sample %0d %0d %0d", curve_x, curve_y,
                                curve_z));
    end else begin
      s = curve_expected.pop_front();
      if (curve_x !== s.x) report_mismatch($sformatf("curve_x %0d exp %0d", curve_x, s.x));
      if (curve_y !== s.y) report_mismatch($sformatf("curve_y %0d exp %0d", curve_y, s.y));
      if (curve_z !== s.z) report_mismatch($sformatf("curve_z %0d exp %0d", curve_z, s.z));
      if (segment_done !== s.last) begin
        report_mismatch($sformatf("segment_done %0b exp %0b", segment_done, s.last));
      end
    end
  endtask

  // idle rates by phase of the run
  always_comb begin
    if (points_taken < total_points / 3) begin
      send_idle_pct = 8;
      recv_idle_pct = 53;
    end else if (points_taken < 2 * total_points / 3) begin
      send_idle_pct = 53;
      recv_idle_pct = 8;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // handshakes are sampled mid-cycle, where inputs and outputs are settled
  always @(negedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        predict_samples('{first: start_path, pt: '{x: point_x, y: point_y, z: point_z}});
        points_taken++;
      end
      if (out_valid && out_ready) begin
        check_sample();
      end
    end
  end

  // driver
  always @(posedge clk) begin
    ctrl_point_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_points.pop_front();
        in_valid <= 1'b1;
        start_path <= it.first;
        point_x <= it.pt.x;
        point_y <= it.pt.y;
        point_z <= it.pt.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall while points keep coming
  initial begin
    wait (total_points != 0 && points_taken >= 2 * total_points / 3 + 4);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (150) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int seg_len;

    push_point(1'b0, 16'sh7fff, 16'sh8000, 16'sh0000);
    push_point(1'b0, 16'sh8000, 16'sh7fff, -16'sd1);
    push_point(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_point(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    push_point(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    push_point(1'b1, 16'sd100, -16'sd200, 16'sd300);
    push_point(1'b0, 16'sd5, 16'sd5, 16'sd5);
    push_point(1'b1, -16'sd7, 16'sd8, -16'sd9);
    push_point(1'b0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    push_point(1'b0, 16'sd1, -16'sd1, 16'sd0);
    push_point(1'b0, 16'sd0, 16'sd0, 16'sd0);
    push_point(1'b0, -16'sd1, -16'sd1, -16'sd1);
    push_point(1'b1, 16'sd0, 16'sd0, 16'sd0);
    push_point(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    push_point(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    push_point(1'b1, 16'sd3, 16'sd2, 16'sd1);
    push_point(1'b0, 16'sh5555, 16'shaaaa, 16'sh2aaa);
    push_point(1'b0, 16'shaaaa, 16'sh5555, 16'shd555);
    push_point(1'b0, 16'sd12, -16'sd34, 16'sd56);

    // random paths, with an occasional stray restart
    while (pending_points.size() < 19 + RANDOM_POINTS) begin
      push_point(1'b1, rand_coord(), rand_coord(), rand_coord());
      seg_len = $urandom_range(12, 1);
      for (int i = 0; i < seg_len; i++) begin
        push_point($urandom_range(14) == 0, rand_coord(), rand_coord(), rand_coord());
      end
    end
    total_points = pending_points.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_points.size() != 0 || in_valid) @(posedge clk);
    while (curve_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (curve_expected.size() != 0) begin
      report_mismatch($sformatf("%0d samples never arrived", curve_expected.size()));
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
